@@ rtl/cpc_pkg.sv @@
`default_nettype none

package cpc_pkg;

  // Fixed payload geometry
  localparam int FIELD_LITS = 16;
  localparam int CODE_W     = 2;
  localparam int ROW_W      = FIELD_LITS * CODE_W;
  localparam int CFG_W      = 9;
  localparam int IDX_IN_W   = 8;

  // Parameter defaults
  localparam int DEF_MAX_INPUTS   = 16;
  localparam int DEF_MAX_OFF_ROWS = 256;

  // Row codes
  localparam logic [CODE_W-1:0] CODE_DASH = 2'd0;
  localparam logic [CODE_W-1:0] CODE_ZERO = 2'd1;
  localparam logic [CODE_W-1:0] CODE_ONE  = 2'd2;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // Control from the sequencer to the merge stage
  typedef struct packed {
    logic clr;  // new check: drop what earlier rows found
    logic en;   // a row word is on the lanes this cycle
  } merge_ctl_t;

endpackage

`default_nettype wire

@@ rtl/cube_prime_check_core.sv @@
`default_nettype none

// Prime-implicant check against an OFF set held in an on-chip table.
// A write word (in_kind = 0) stores one OFF row and leaves busy low; it
// gives no result. A check word (in_kind = 1) streams the first off_row_count
// rows out of the table, one row per cycle through the single read port,
// while 16 literal lanes test every single-literal deletion against that row
// at once. busy stays high until the reads of count rows are issued and the
// read stage has drained, where count is off_row_count capped at MAX_OFF_ROWS;
// out_valid is then high for exactly one cycle, with out_is_prime. The
// receiver cannot stall: a result must be taken in the cycle it appears. A
// new word may start in that same cycle. cfg_ready is low while a check runs.
module cube_prime_check_core
  import cpc_pkg::*;
#(
  parameter int MAX_INPUTS   = DEF_MAX_INPUTS,
  parameter int MAX_OFF_ROWS = DEF_MAX_OFF_ROWS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command side
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_kind,
  input  wire logic [IDX_IN_W-1:0]   in_row_index,
  input  wire logic [ROW_W-1:0]      in_row_codes,
  input  wire logic [FIELD_LITS-1:0] in_support_mask,
  input  wire logic [FIELD_LITS-1:0] in_cube_values,
  // result side
  output logic                       out_valid,
  output logic                       out_is_prime,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int AW = (MAX_OFF_ROWS > 1) ? $clog2(MAX_OFF_ROWS) : 1;
  localparam int CW = $clog2(MAX_OFF_ROWS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      off_row_count_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [FIELD_LITS-1:0] sup_r, sup_nxt;
  logic [FIELD_LITS-1:0] val_r, val_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_is_prime_r, out_is_prime_nxt;
  logic [ROW_W-1:0]      rd_data_r;
  logic [ROW_W-1:0]      mem [MAX_OFF_ROWS];

  logic                  accept;
  logic                  wr_en;
  logic                  rd_en;
  logic [FIELD_LITS-1:0] sup_in;
  logic [FIELD_LITS-1:0] conflicts;
  logic [FIELD_LITS-1:0] blocked;
  logic [CW-1:0]         cnt_sat;
  merge_ctl_t            mctl;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign wr_en     = accept && (in_kind == KIND_WRITE) &&
                     (32'(in_row_index) < MAX_OFF_ROWS);

  // Inputs beyond MAX_INPUTS carry no literal
  for (genvar i = 0; i < FIELD_LITS; i++) begin : g_sup
    assign sup_in[i] = (i < MAX_INPUTS) ? in_support_mask[i] : 1'b0;
  end

  // Row count capped at the table depth
  assign cnt_sat = (32'(off_row_count_r) > MAX_OFF_ROWS) ? CW'(MAX_OFF_ROWS)
                                                          : CW'(off_row_count_r);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_row_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      off_row_count_r <= cfg_data;
    end
  end

  // Row table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(in_row_index)] <= in_row_codes;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  // Sequencer: issue reads, drain the read stage, then post the result
  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    idx_nxt          = idx_r;
    sup_nxt          = sup_r;
    val_nxt          = val_r;
    rd_vld_nxt       = 1'b0;
    rd_en            = 1'b0;
    out_valid_nxt    = 1'b0;
    out_is_prime_nxt = out_is_prime_r;
    mctl.clr         = 1'b0;
    mctl.en          = rd_vld_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_CHECK)) begin
          state_nxt = ST_RUN;
          cnt_nxt   = cnt_sat;
          idx_nxt   = '0;
          sup_nxt   = sup_in;
          val_nxt   = in_cube_values;
          mctl.clr  = 1'b1;
        end
      end
      ST_RUN: begin
        if (idx_r < cnt_r) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + CW'(1);
        end else if (!rd_vld_r) begin
          state_nxt        = ST_IDLE;
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = (sup_r != '0) && (blocked == sup_r);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r          <= cnt_nxt;
    idx_r          <= idx_nxt;
    sup_r          <= sup_nxt;
    val_r          <= val_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  // One lane per literal
  for (genvar i = 0; i < FIELD_LITS; i++) begin : g_lane
    cpc_lane u_lane (
      .sup      (sup_r[i]),
      .val      (val_r[i]),
      .code     (rd_data_r[CODE_W*i +: CODE_W]),
      .conflict (conflicts[i])
    );
  end

  // Fold each row's findings into the blocked set
  cpc_merge u_merge (
    .clk       (clk),
    .ctl       (mctl),
    .support   (sup_r),
    .conflicts (conflicts),
    .blocked   (blocked)
  );

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

endmodule

`default_nettype wire

@@ rtl/cpc_lane.sv @@
`default_nettype none

module cpc_lane
  import cpc_pkg::*;
(
  input  wire logic              sup,
  input  wire logic              val,
  input  wire logic [CODE_W-1:0] code,
  output logic                   conflict
);

  // A literal conflicts when the row holds a fixed value other than the cube's
  always_comb begin
    conflict = sup && (code != CODE_DASH) && (code != (val ? CODE_ONE : CODE_ZERO));
  end

endmodule

`default_nettype wire

@@ rtl/cpc_merge.sv @@
`default_nettype none

module cpc_merge
  import cpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire merge_ctl_t            ctl,
  input  wire logic [FIELD_LITS-1:0] support,
  input  wire logic [FIELD_LITS-1:0] conflicts,
  output logic      [FIELD_LITS-1:0] blocked
);

  logic [FIELD_LITS-1:0] blocked_r;
  logic [FIELD_LITS-1:0] blocked_nxt;
  logic                  single;

  // At most one conflict: the row blocks that literal's deletion
  assign single = ((conflicts & (conflicts - FIELD_LITS'(1))) == '0);

  always_comb begin
    blocked_nxt = blocked_r;
    if (ctl.clr) begin
      blocked_nxt = '0;
    end else if (ctl.en) begin
      if (conflicts == '0) begin
        blocked_nxt = support;
      end else if (single) begin
        blocked_nxt = blocked_r | conflicts;
      end
    end
  end

  always_ff @(posedge clk) begin
    blocked_r <= blocked_nxt;
  end

  assign blocked = blocked_r;

endmodule

`default_nettype wire
